// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

   localparam int unsigned Depth        = 16;
   localparam int unsigned PayloadBits  = 16;
   localparam int unsigned PriorityBits = 16;
   localparam int unsigned CountBits    = $clog2(Depth + 1);

   typedef enum logic [0:0] {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      command_type             command;
      logic [PayloadBits-1:0]  payload_in;
      logic [PriorityBits-1:0] priority_in;
   } req_type;

   typedef struct packed {
      logic [PayloadBits-1:0] payload_out;
      status_type             status;
      logic [CountBits-1:0]   occupancy;
   } rsp_type;

   typedef struct packed {
      logic [PayloadBits-1:0]  payload;
      logic [PriorityBits-1:0] prio;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

// ===== design/sorted_priority_queue_core.sv =====
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after acceptance. The
// core takes one request per cycle unless a held result stalls on rsp_ready;
// every cell of the row updates in the same cycle from its own compare and
// its two neighbors. Reset clears the entry count and the result valid flag;
// cell contents are left as they are and only occupied cells are ever read.
module sorted_priority_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   logic [spq_pkg::CountBits-1:0] count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_type              rsp_ff, rsp_in;

   spq_pkg::cell_ctrl_type        ctrl;
   spq_pkg::entry_type            entries [spq_pkg::Depth];
   logic                          after [spq_pkg::Depth];

   logic                          accept;
   logic                          full;
   logic                          empty;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == spq_pkg::CountBits'(spq_pkg::Depth));
   assign empty     = (count_ff == '0);

   assign ctrl.enq = accept && (req_data.command == spq_pkg::CMD_ENQUEUE) && !full;
   assign ctrl.deq = accept && (req_data.command == spq_pkg::CMD_DEQUEUE) && !empty;
   assign ctrl.new_entry.payload = req_data.payload_in;
   assign ctrl.new_entry.prio    = req_data.priority_in;

   for (genvar i = 0; i < spq_pkg::Depth; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic               left_after;
      logic               occupied;

      assign occupied = (spq_pkg::CountBits'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_entry = ctrl.new_entry;
         assign left_after = 1'b1;
      end else begin : g_body
         assign left_entry = entries[i-1];
         assign left_after = after[i-1];
      end

      // the tail cell shifts in its own content; the count drops past it
      if (i == spq_pkg::Depth - 1) begin : g_tail
         assign right_entry = entries[i];
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_entry  (left_entry),
         .left_after  (left_after),
         .right_entry (right_entry),
         .entry_out   (entries[i]),
         .after_out   (after[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.enq) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.deq) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in       = 1'b1;
         rsp_in.payload_out = '0;
         rsp_in.status      = spq_pkg::STATUS_DONE;
         rsp_in.occupancy   = count_in;
         unique case (req_data.command)
            spq_pkg::CMD_ENQUEUE: begin
               if (full) begin
                  rsp_in.status = spq_pkg::STATUS_FULL;
               end
            end
            spq_pkg::CMD_DEQUEUE: begin
               if (empty) begin
                  rsp_in.status = spq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_in.payload_out = entries[0].payload;
               end
            end
            default: begin
               rsp_in.status = spq_pkg::STATUS_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  spq_pkg::entry_type    left_entry,
   input  logic                  left_after,
   input  spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type    entry_out,
   output logic                  after_out
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // new entry belongs behind this one: equal priorities stay first-in first-out
   assign after_out = occupied && (entry_ff.prio >= ctrl.new_entry.prio);
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.enq) begin
         priority if (after_out) begin
            entry_in = entry_ff;
         end else if (left_after) begin
            entry_in = ctrl.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== bench/sorted_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps
module sorted_priority_queue_core_tb;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   spq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   spq_pkg::rsp_type rsp_data;

   sorted_priority_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // shadow copy of the sorted row, slot 0 is the head
   logic [spq_pkg::PayloadBits-1:0]  held_payload [spq_pkg::Depth];
   logic [spq_pkg::PriorityBits-1:0] held_prio    [spq_pkg::Depth];
   int unsigned                      held_count;

   spq_pkg::rsp_type pending_responses [$];
   spq_pkg::rsp_type oldest_response;
   int unsigned      mismatch_count;
   int unsigned      burst_left;
   int unsigned      hold_off_cycles;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic spq_pkg::rsp_type predict_response(spq_pkg::req_type r);
      spq_pkg::rsp_type res;
      int unsigned      slot;
      res.payload_out = '0;
      res.status      = spq_pkg::STATUS_DONE;
      if (r.command == spq_pkg::CMD_ENQUEUE) begin
         if (held_count >= spq_pkg::Depth) begin
            res.status = spq_pkg::STATUS_FULL;
         end else begin
            // new entry goes behind every entry of equal or higher priority
            slot = 0;
            while (slot < held_count && held_prio[slot] >= r.priority_in)
               slot++;
            for (int k = held_count; k > slot; k--) begin
               held_payload[k] = held_payload[k-1];
               held_prio[k]    = held_prio[k-1];
            end
            held_payload[slot] = r.payload_in;
            held_prio[slot]    = r.priority_in;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            res.status = spq_pkg::STATUS_EMPTY;
         end else begin
            res.payload_out = held_payload[0];
            for (int k = 1; k < held_count; k++) begin
               held_payload[k-1] = held_payload[k];
               held_prio[k-1]    = held_prio[k];
            end
            held_count--;
         end
      end
      res.occupancy = spq_pkg::CountBits'(held_count);
      return res;
   endfunction

   // call right after a rising edge; returns at the edge that takes the request
   task automatic send_request(input spq_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(predict_response(r));
   endtask

   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic test_dequeue_empty();
      spq_pkg::req_type r;
      r.command     = spq_pkg::CMD_DEQUEUE;
      r.payload_in  = '1;
      r.priority_in = '1;
      send_request(r);
      r.payload_in  = '0;
      r.priority_in = '0;
      send_request(r);
      drain_responses();
   endtask

   // fill with extremes and ties, overflow twice, then empty past the bottom
   task automatic test_fill_and_overflow();
      logic [spq_pkg::PriorityBits-1:0] fill_prio [16] = '{
         16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
         16'h0000, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h8001, 16'h7FFE, 16'h1234};
      logic [spq_pkg::PayloadBits-1:0] fill_payload [16] = '{
         16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
         16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h0F0F, 16'hF0F0, 16'h7FFF, 16'hFFFE};
      spq_pkg::req_type r;
      r.command = spq_pkg::CMD_ENQUEUE;
      for (int i = 0; i < 16; i++) begin
         r.payload_in  = fill_payload[i];
         r.priority_in = fill_prio[i];
         send_request(r);
      end
      r.payload_in  = 16'hDEAD;
      r.priority_in = '1;
      send_request(r);
      r.priority_in = '0;
      send_request(r);
      r.command = spq_pkg::CMD_DEQUEUE;
      for (int i = 0; i < 17; i++) begin
         r.payload_in  = 16'(i);
         r.priority_in = 16'(~i);
         send_request(r);
      end
      drain_responses();
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned enqueue_pct,
                                      input bit with_gaps);
      spq_pkg::req_type r;
      int unsigned      pick;
      for (int i = 0; i < count; i++) begin
         r.command    = ($urandom_range(0, 99) < enqueue_pct) ? spq_pkg::CMD_ENQUEUE
                                                              : spq_pkg::CMD_DEQUEUE;
         r.payload_in = spq_pkg::PayloadBits'($urandom());
         pick = $urandom_range(0, 9);
         // narrow ranges force long runs of equal priority
         if (pick < 4)
            r.priority_in = spq_pkg::PriorityBits'($urandom_range(0, 3));
         else if (pick == 4)
            r.priority_in = $urandom_range(0, 1) ? '1 : '0;
         else if (pick == 5)
            r.priority_in = spq_pkg::PriorityBits'(16'hFFFF - $urandom_range(0, 3));
         else
            r.priority_in = spq_pkg::PriorityBits'($urandom());
         if (with_gaps)
            pace_sender();
         send_request(r);
      end
      drain_responses();
   endtask

   task automatic test_backpressure();
      spq_pkg::req_type r;
      hold_off_cycles = 200;
      for (int i = 0; i < 60; i++) begin
         r.command     = ($urandom_range(0, 99) < 60) ? spq_pkg::CMD_ENQUEUE
                                                      : spq_pkg::CMD_DEQUEUE;
         r.payload_in  = spq_pkg::PayloadBits'($urandom());
         r.priority_in = spq_pkg::PriorityBits'($urandom_range(0, 7));
         send_request(r);
      end
      drain_responses();
   endtask

   initial begin : receiver
      int unsigned stretch;
      int unsigned style;
      int unsigned tick;
      rsp_ready <= 1'b0;
      tick = 0;
      forever begin
         stretch = $urandom_range(8, 60);
         style   = $urandom_range(0, 3);
         repeat (stretch) begin
            @(posedge clock);
            tick++;
            if (hold_off_cycles != 0) begin
               rsp_ready <= 1'b0;
               repeat (hold_off_cycles) @(posedge clock);
               hold_off_cycles = 0;
            end else begin
               case (style)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= ($urandom_range(0, 99) < 50);
                  2:       rsp_ready <= ($urandom_range(0, 99) < 85);
                  default: rsp_ready <= (tick % 3 != 0);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: payload=%h status=%0d occupancy=%0d",
                        rsp_data.payload_out, rsp_data.status, rsp_data.occupancy);
         end else begin
            oldest_response = pending_responses.pop_front();
            if (rsp_data.payload_out !== oldest_response.payload_out ||
                rsp_data.status !== oldest_response.status ||
                rsp_data.occupancy !== oldest_response.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: expected %h/%0d/%0d, got %h/%0d/%0d",
                           $realtime, oldest_response.payload_out, oldest_response.status,
                           oldest_response.occupancy, rsp_data.payload_out, rsp_data.status,
                           rsp_data.occupancy);
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      held_count      = 0;
      mismatch_count  = 0;
      burst_left      = 0;
      hold_off_cycles = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_dequeue_empty();
      test_fill_and_overflow();
      test_random_traffic(250, 80, 1'b1);
      test_random_traffic(250, 25, 1'b1);
      test_backpressure();
      test_random_traffic(200, 50, 1'b0);
      test_random_traffic(250, 70, 1'b1);
      test_random_traffic(250, 30, 1'b1);
      test_random_traffic(150, 95, 1'b0);
      test_random_traffic(150, 5, 1'b1);

      drain_responses();
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sorted_priority_queue_core.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_core.sv
bench/sorted_priority_queue_core_tb.sv
